// ===== hdl/load_cell_adc_serial_reader_assert.svh =====
// Assertion macros for the load cell ADC serial reader.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef LOAD_CELL_ADC_SERIAL_READER_ASSERT_SVH
`define LOAD_CELL_ADC_SERIAL_READER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LCASR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCASR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lcasr_pkg.sv =====
// Shared widths, command codes and register indexes of the load cell ADC reader.
// No dependencies; used by the channel interfaces and the top level.
package lcasr_pkg;

    localparam int CMD_W      = 2;
    localparam int READ_W     = 24;
    localparam int WEIGHT_W   = 32;
    localparam int HALF_W     = 8;
    localparam int TIMEOUT_W  = 24;
    localparam int SCALE_W    = 24;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TARE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WEIGH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READY_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 2'd2;

    localparam logic [HALF_W-1:0]    HALF_RESET    = 8'd1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd100000;
    localparam logic [SCALE_W-1:0]   SCALE_RESET   = 24'd256;

endpackage

// ===== hdl/lcasr_sample_if.sv =====
// Tick channel of the load cell ADC reader: command and sensor data level.
// Depends on lcasr_pkg for field widths.
interface lcasr_sample_if;
    logic                        valid;
    logic                        ready;
    logic [lcasr_pkg::CMD_W-1:0] cmd;
    logic                        data_level;

    modport source (output valid, output cmd, output data_level, input ready);
    modport sink   (input valid, input cmd, input data_level, output ready);
endinterface

// ===== hdl/lcasr_result_if.sv =====
// Result channel of the load cell ADC reader: one word per tick.
// Depends on lcasr_pkg for field widths.
interface lcasr_result_if;
    logic                           valid;
    logic                           ready;
    logic                           serial_clock;
    logic                           busy_res;
    logic                           done_res;
    logic [lcasr_pkg::READ_W-1:0]   raw_reading;
    logic [lcasr_pkg::READ_W-1:0]   zero_reading;
    logic [lcasr_pkg::WEIGHT_W-1:0] weight;
    logic                           error;

    modport source (output valid, output serial_clock, output busy_res, output done_res,
                    output raw_reading, output zero_reading, output weight, output error,
                    input ready);
    modport sink   (input valid, input serial_clock, input busy_res, input done_res,
                    input raw_reading, input zero_reading, input weight, input error,
                    output ready);
endinterface

// ===== hdl/lcasr_cfg_if.sv =====
// Configuration write channel of the load cell ADC reader.
// Depends on lcasr_pkg for index and data widths.
interface lcasr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lcasr_pkg::CFG_IDX_W-1:0]  index;
    logic [lcasr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/load_cell_adc_serial_reader.sv =====
// Load cell ADC serial reader. Every word on the sample channel is one protocol tick and
// yields exactly one result word: serial clock level, busy, done, readings, weight, error.
// A tick's result word is normally held in the output register from the cycle after
// acceptance; the next tick is taken in the cycle that word is consumed. A weigh conversion
// that finishes above the tare with a non-zero scale holds its word back, and takes no new
// tick, while the restoring divide unit produces one quotient bit per cycle.
// Depends on lcasr_pkg, the three channel interfaces and the assertion header.
`include "load_cell_adc_serial_reader_assert.svh"

module load_cell_adc_serial_reader #(
    parameter int DATA_BITS    = 24,
    parameter int EXTRA_PULSES = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    lcasr_sample_if.sink  sample,
    lcasr_result_if.source result,
    lcasr_cfg_if.sink     cfg
);

    localparam int READ_W    = lcasr_pkg::READ_W;
    localparam int WEIGHT_W  = lcasr_pkg::WEIGHT_W;
    localparam int SCALE_W   = lcasr_pkg::SCALE_W;
    localparam int TIMEOUT_W = lcasr_pkg::TIMEOUT_W;
    localparam int HALF_W    = lcasr_pkg::HALF_W;
    localparam int FRAC_W    = lcasr_pkg::FRAC_W;

    localparam int BC_W  = $clog2(DATA_BITS + EXTRA_PULSES + 1);
    localparam int DCNT_W = $clog2(WEIGHT_W);

    localparam logic [BC_W-1:0]      BC_DATA  = BC_W'(DATA_BITS);
    localparam logic [BC_W-1:0]      BC_LAST  = BC_W'(DATA_BITS + EXTRA_PULSES);
    localparam logic [DCNT_W-1:0]    DIV_LAST = DCNT_W'(WEIGHT_W - 1);
    localparam logic [DATA_BITS-1:0] SIGN_BIT = {1'b1, {(DATA_BITS - 1){1'b0}}};

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;
    localparam logic [1:0] PH_LOW  = 2'd3;

    localparam logic SEQ_RUN = 1'b0;
    localparam logic SEQ_DIV = 1'b1;

    // configuration
    logic [HALF_W-1:0]    half_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [SCALE_W-1:0]   scale_reg;

    // conversion state; it also forms the held result word
    logic [1:0]           phase_reg, phase_next;
    logic                 op_reg, op_next;
    logic [TIMEOUT_W-1:0] tick_reg, tick_next;
    logic [BC_W-1:0]      bit_reg, bit_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [READ_W-1:0]    last_reg, last_next;
    logic [READ_W-1:0]    tare_reg, tare_next;
    logic [WEIGHT_W-1:0]  weight_reg, weight_next;
    logic                 error_reg, error_next;
    logic                 clock_level_reg, clock_level_next;
    logic                 done_reg, done_next;
    logic                 out_valid_reg, out_valid_next;

    // sequencer and divide unit
    logic                 seq_reg, seq_next;
    logic [DCNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [SCALE_W-1:0]   rem_reg, rem_next;
    logic [WEIGHT_W-1:0]  quot_reg, quot_next;

    logic                 in_ready;
    logic                 accept;
    logic [HALF_W-1:0]    half_eff;
    logic [TIMEOUT_W-1:0] tick_inc;
    logic                 finish_now;
    logic [READ_W-1:0]    finish_val;
    logic [READ_W-1:0]    diff;
    logic [SCALE_W:0]     rem_shift;
    logic [SCALE_W:0]     rem_sub;
    logic                 rem_ge;

    assign in_ready     = (seq_reg == SEQ_RUN) && (!out_valid_reg || result.ready);
    assign accept       = sample.valid && in_ready;
    assign sample.ready = in_ready;
    assign cfg.ready    = 1'b1;

    assign half_eff = (half_reg == '0) ? HALF_W'(1) : half_reg;
    assign tick_inc = tick_reg + TIMEOUT_W'(1);

    // compare-subtract: one restoring step per cycle
    assign rem_shift = {rem_reg, quot_reg[WEIGHT_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, scale_reg};
    assign rem_sub   = rem_shift - {1'b0, scale_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        op_next          = op_reg;
        tick_next        = tick_reg;
        bit_next         = bit_reg;
        shift_next       = shift_reg;
        last_next        = last_reg;
        tare_next        = tare_reg;
        weight_next      = weight_reg;
        error_next       = error_reg;
        clock_level_next = clock_level_reg;
        done_next        = done_reg;
        out_valid_next   = out_valid_reg;
        seq_next         = seq_reg;
        div_cnt_next     = div_cnt_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        finish_now       = 1'b0;
        finish_val       = '0;
        diff             = '0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            done_next      = 1'b0;
            out_valid_next = 1'b1;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (sample.cmd == lcasr_pkg::CMD_TARE || sample.cmd == lcasr_pkg::CMD_WEIGH)
                    begin
                        op_next    = (sample.cmd == lcasr_pkg::CMD_WEIGH);
                        phase_next = PH_WAIT;
                        tick_next  = '0;
                        bit_next   = '0;
                        shift_next = '0;
                    end
                    clock_level_next = 1'b0;
                end
                PH_WAIT:
                begin
                    if (!sample.data_level)
                    begin
                        phase_next       = PH_HIGH;
                        clock_level_next = 1'b1;
                        tick_next        = '0;
                    end
                    else if (tick_reg >= timeout_reg)
                    begin
                        error_next = 1'b1;
                        finish_now = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                PH_HIGH:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= TIMEOUT_W'(half_eff))
                    begin
                        phase_next       = PH_LOW;
                        clock_level_next = 1'b0;
                        tick_next        = '0;
                        // sample just after the falling edge
                        if (bit_reg < BC_DATA)
                        begin
                            shift_next = {shift_reg[DATA_BITS-2:0], sample.data_level};
                        end
                        bit_next = bit_reg + BC_W'(1);
                    end
                end
                default:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= TIMEOUT_W'(half_eff))
                    begin
                        if (bit_reg < BC_LAST)
                        begin
                            phase_next       = PH_HIGH;
                            clock_level_next = 1'b1;
                            tick_next        = '0;
                        end
                        else
                        begin
                            finish_now = 1'b1;
                            finish_val = READ_W'(shift_reg ^ SIGN_BIT);
                        end
                    end
                end
            endcase

            if (finish_now)
            begin
                done_next        = 1'b1;
                phase_next       = PH_IDLE;
                clock_level_next = 1'b0;
                tick_next        = '0;
                if (!op_reg)
                begin
                    tare_next = finish_val;
                end
                else
                begin
                    last_next = finish_val;
                    diff      = finish_val - tare_reg;
                    if (finish_val <= tare_reg)
                    begin
                        weight_next = '0;
                    end
                    else if (scale_reg == '0)
                    begin
                        weight_next = '1;
                    end
                    else
                    begin
                        // hold the word back until the quotient is in
                        out_valid_next = 1'b0;
                        seq_next       = SEQ_DIV;
                        div_cnt_next   = '0;
                        rem_next       = '0;
                        quot_next      = WEIGHT_W'({diff, {FRAC_W{1'b0}}});
                    end
                end
            end
        end

        if (seq_reg == SEQ_DIV)
        begin
            rem_next     = rem_ge ? rem_sub[SCALE_W-1:0] : rem_shift[SCALE_W-1:0];
            quot_next    = {quot_reg[WEIGHT_W-2:0], rem_ge};
            div_cnt_next = div_cnt_reg + DCNT_W'(1);
            if (div_cnt_reg == DIV_LAST)
            begin
                weight_next    = {quot_reg[WEIGHT_W-2:0], rem_ge};
                out_valid_next = 1'b1;
                seq_next       = SEQ_RUN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg        <= lcasr_pkg::HALF_RESET;
            timeout_reg     <= lcasr_pkg::TIMEOUT_RESET;
            scale_reg       <= lcasr_pkg::SCALE_RESET;
            phase_reg       <= PH_IDLE;
            op_reg          <= 1'b0;
            tick_reg        <= '0;
            bit_reg         <= '0;
            shift_reg       <= '0;
            last_reg        <= '0;
            tare_reg        <= '0;
            weight_reg      <= '0;
            error_reg       <= 1'b0;
            clock_level_reg <= 1'b0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            seq_reg         <= SEQ_RUN;
            div_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    lcasr_pkg::REG_HALF_PERIOD:   half_reg    <= cfg.data[HALF_W-1:0];
                    lcasr_pkg::REG_READY_TIMEOUT: timeout_reg <= cfg.data[TIMEOUT_W-1:0];
                    lcasr_pkg::REG_SCALE:         scale_reg   <= cfg.data[SCALE_W-1:0];
                    default:                      ;
                endcase
            end
            phase_reg       <= phase_next;
            op_reg          <= op_next;
            tick_reg        <= tick_next;
            bit_reg         <= bit_next;
            shift_reg       <= shift_next;
            last_reg        <= last_next;
            tare_reg        <= tare_next;
            weight_reg      <= weight_next;
            error_reg       <= error_next;
            clock_level_reg <= clock_level_next;
            done_reg        <= done_next;
            out_valid_reg   <= out_valid_next;
            seq_reg         <= seq_next;
            div_cnt_reg     <= div_cnt_next;
        end
    end

    // divide operands carry no reset
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.serial_clock = clock_level_reg;
    assign result.busy_res     = (phase_reg != PH_IDLE);
    assign result.done_res     = done_reg;
    assign result.raw_reading  = last_reg;
    assign result.zero_reading = tare_reg;
    assign result.weight       = weight_reg;
    assign result.error        = error_reg;

    `LCASR_ASSERT_IMPLY(a_no_take_while_div, seq_reg == SEQ_DIV, !in_ready, "tick taken during divide")
    `LCASR_ASSERT_NEXT(a_div_ends_with_word, (seq_reg == SEQ_DIV) && (div_cnt_reg == DIV_LAST), (seq_reg == SEQ_RUN) && out_valid_reg, "divide did not release the word")
    `LCASR_ASSERT_IMPLY(a_clock_only_high, clock_level_reg, phase_reg == PH_HIGH, "serial clock high outside high phase")
    `LCASR_ASSERT_IMPLY(a_done_is_idle, done_reg, (phase_reg == PH_IDLE) && !clock_level_reg, "done while busy")
    `LCASR_ASSERT_IMPLY(a_bit_count_range, phase_reg != PH_IDLE, bit_reg <= BC_LAST, "bit count overran")

endmodule
